[design/dets_pkg.sv]
`default_nettype none

package dets_pkg;

   // Field widths
   localparam int FUNC_W = 2;
   localparam int SYM_W = 8;
   localparam int STATE_W = 4;
   localparam int MASK_W = 16;

   // Defaults for the top-level parameters
   localparam int MAX_EDGES = 64;

   // States at or above this number never accept
   localparam int NUM_STATES = 16;

   // Function codes of a request
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

   // Configuration registers
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_MASK = 1'd1;

   typedef struct packed {
      logic [STATE_W-1:0] origin;
      logic [SYM_W-1:0]   symbol;
      logic [STATE_W-1:0] target;
   } edge_entry_type;

   // Controller to datapath
   typedef struct packed {
      logic other_accept;   // non-step transaction accepted this cycle
      logic scan_start;     // step transaction accepted this cycle
      logic scan_run;       // edge scan in progress
   } dets_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } dets_sts_type;

endpackage

`default_nettype wire

[design/dets_if.sv]
`default_nettype none

interface dets_req_if;
   logic                          valid;
   logic                          ready;
   logic [dets_pkg::FUNC_W-1:0]   func;
   logic [dets_pkg::SYM_W-1:0]    symbol;
   logic [dets_pkg::STATE_W-1:0]  edge_origin;
   logic [dets_pkg::STATE_W-1:0]  edge_target;

   modport source (output valid, output func, output symbol, output edge_origin,
                   output edge_target, input ready);
   modport sink (input valid, input func, input symbol, input edge_origin,
                 input edge_target, output ready);
endinterface

interface dets_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dets_pkg::STATE_W-1:0]  current_state;
   logic                          matched;
   logic                          accepting;
   logic                          table_full;

   modport source (output valid, output current_state, output matched,
                   output accepting, output table_full, input ready);
   modport sink (input valid, input current_state, input matched,
                 input accepting, input table_full, output ready);
endinterface

interface dets_csr_if;
   logic                             valid;
   logic                             ready;
   logic [dets_pkg::CSR_IDX_W-1:0]   index;
   logic [dets_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/dets_ctrl.sv]
`default_nettype none

module dets_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_is_step,
   output logic                        req_ready,
   input  wire dets_pkg::dets_sts_type sts,
   output dets_pkg::dets_cmd_type      cmd
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_SCAN = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE) && sts.out_free;
   assign accept = req_valid && req_ready;

   always_comb begin
      cmd.other_accept = accept && !req_is_step;
      cmd.scan_start = accept && req_is_step;
      cmd.scan_run = (state_ff == ST_SCAN);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_is_step) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/dets_datapath.sv]
`default_nettype none

module dets_datapath #(
   parameter int MAX_EDGES = dets_pkg::MAX_EDGES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dets_pkg::dets_cmd_type            cmd,
   output dets_pkg::dets_sts_type                 sts,
   // request payload
   input  wire logic [dets_pkg::FUNC_W-1:0]       func,
   input  wire logic [dets_pkg::SYM_W-1:0]        symbol,
   input  wire logic [dets_pkg::STATE_W-1:0]      edge_origin,
   input  wire logic [dets_pkg::STATE_W-1:0]      edge_target,
   // configuration writes
   input  wire logic                              csr_write,
   input  wire logic [dets_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dets_pkg::CSR_DATA_W-1:0]   csr_data,
   // response
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output logic [dets_pkg::STATE_W-1:0]           rsp_current_state,
   output logic                                   rsp_matched,
   output logic                                   rsp_accepting,
   output logic                                   rsp_table_full
);

   localparam int CNT_W = $clog2(MAX_EDGES + 1);
   localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

   dets_pkg::edge_entry_type edge_mem [MAX_EDGES];

   logic [CNT_W-1:0]                edge_count_ff, edge_count_in;
   logic [CNT_W-1:0]                rd_ptr_ff, rd_ptr_in;
   logic                            rd_pend_ff, rd_pend_in;
   dets_pkg::edge_entry_type        rd_data_ff;
   logic [dets_pkg::SYM_W-1:0]      step_sym_ff;
   logic [dets_pkg::STATE_W-1:0]    cur_state_ff, cur_state_in;
   logic [dets_pkg::STATE_W-1:0]    start_state_ff;
   logic [dets_pkg::MASK_W-1:0]     accept_mask_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [dets_pkg::STATE_W-1:0]    out_state_ff;
   logic                            out_matched_ff, out_matched_in;
   logic                            out_accept_ff, out_accept_in;
   logic                            out_full_ff, out_full_in;

   logic                            table_full;
   logic                            do_append;
   logic                            rd_issue;
   logic                            hit;
   logic                            scan_done;
   logic                            load_out;

   assign table_full = (edge_count_ff == CNT_W'(MAX_EDGES));
   assign do_append = cmd.other_accept && (func == dets_pkg::FUNC_APPEND) && !table_full;

   // Reads go out one per cycle; the compare works on the previous read
   assign rd_issue = cmd.scan_run && (rd_ptr_ff < edge_count_ff);
   assign hit = rd_pend_ff && (rd_data_ff.origin == cur_state_ff)
                && (rd_data_ff.symbol == step_sym_ff);
   assign scan_done = cmd.scan_run && (hit || !rd_issue);
   assign load_out = cmd.other_accept || scan_done;

   assign sts.scan_done = scan_done;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      edge_count_in = edge_count_ff;
      if (do_append) begin
         edge_count_in = edge_count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      rd_pend_in = rd_pend_ff;
      if (cmd.scan_start) begin
         rd_ptr_in = '0;
         rd_pend_in = 1'b0;
      end else if (cmd.scan_run) begin
         rd_pend_in = rd_issue;
         if (rd_issue) begin
            rd_ptr_in = rd_ptr_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      cur_state_in = cur_state_ff;
      out_matched_in = 1'b0;
      out_full_in = 1'b0;
      if (cmd.other_accept) begin
         unique case (func)
            dets_pkg::FUNC_APPEND: out_full_in = table_full;
            dets_pkg::FUNC_RESTART: cur_state_in = start_state_ff;
            default: ;
         endcase
      end else if (scan_done && hit) begin
         cur_state_in = rd_data_ff.target;
         out_matched_in = 1'b1;
      end
      out_accept_in = (32'(cur_state_in) < dets_pkg::NUM_STATES)
                      && accept_mask_ff[cur_state_in];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= '0;
         cur_state_ff <= '0;
         start_state_ff <= '0;
         accept_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ptr_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         edge_count_ff <= edge_count_in;
         cur_state_ff <= cur_state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ptr_ff <= rd_ptr_in;
         rd_pend_ff <= rd_pend_in;
         if (csr_write) begin
            unique case (csr_index)
               dets_pkg::CSR_START_STATE: start_state_ff <= csr_data[dets_pkg::STATE_W-1:0];
               dets_pkg::CSR_ACCEPT_MASK: accept_mask_ff <= csr_data[dets_pkg::MASK_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Edge table
   always_ff @(posedge clock) begin
      if (do_append) begin
         edge_mem[edge_count_ff[ADDR_W-1:0]] <= '{origin: edge_origin, symbol: symbol,
                                                  target: edge_target};
      end
      if (rd_issue) begin
         rd_data_ff <= edge_mem[rd_ptr_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         step_sym_ff <= symbol;
      end
      if (load_out) begin
         out_state_ff <= cur_state_in;
         out_matched_ff <= out_matched_in;
         out_accept_ff <= out_accept_in;
         out_full_ff <= out_full_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_current_state = out_state_ff;
   assign rsp_matched = out_matched_ff;
   assign rsp_accepting = out_accept_ff;
   assign rsp_table_full = out_full_ff;

endmodule

`default_nettype wire

[design/dfa_edge_table_step.sv]
// Programmable table-driven automaton matcher.
// req_if carries one transaction per item: func selects append edge, step on
// symbol or restart at the start state; code 3 only reports the state.
// rsp_if returns exactly one transaction per request: the state after the
// item, its accept bit, whether a step matched an edge, and whether an
// append was dropped because the edge table was full.
// csr_if writes start_state (index 0) and accept_mask (index 1); it is
// always ready and is to be written only while no request is outstanding.
// For append, restart and code 3 the result is registered at the
// accepting edge. A step walks the edge table in load order through one
// memory read port, one edge per cycle, and ends at the first edge that
// matches the state and symbol or after the last stored edge.
// One request is handled at a time. A new request is taken as soon as the
// output register is empty or being drained; a stalled rsp_if holds the
// result and blocks further requests.
// Reset empties the edge table and the output register and clears the state
// and both registers; no clearing pass is needed.
`default_nettype none

module dfa_edge_table_step #(
   parameter int MAX_EDGES = dets_pkg::MAX_EDGES
) (
   input  wire logic     clock,
   input  wire logic     reset,
   dets_req_if.sink      req_if,
   dets_rsp_if.source    rsp_if,
   dets_csr_if.sink      csr_if
);

   dets_pkg::dets_cmd_type cmd;
   dets_pkg::dets_sts_type sts;
   logic                   req_ready;

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;

   dets_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_is_step (req_if.func == dets_pkg::FUNC_STEP),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   dets_datapath #(
      .MAX_EDGES (MAX_EDGES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .func              (req_if.func),
      .symbol            (req_if.symbol),
      .edge_origin       (req_if.edge_origin),
      .edge_target       (req_if.edge_target),
      .csr_write         (csr_if.valid),
      .csr_index         (csr_if.index),
      .csr_data          (csr_if.data),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_current_state (rsp_if.current_state),
      .rsp_matched       (rsp_if.matched),
      .rsp_accepting     (rsp_if.accepting),
      .rsp_table_full    (rsp_if.table_full)
   );

endmodule

`default_nettype wire

[tb/dfa_edge_table_step_test.sv]
`timescale 1ns / 100ps

module dfa_edge_table_step_test;

   // unused code, only reports the state
   localparam logic [dets_pkg::FUNC_W-1:0] FUNC_REPORT = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 80;
   localparam int HOLD_AFTER = 120;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [dets_pkg::FUNC_W-1:0]  func;
      logic [dets_pkg::SYM_W-1:0]   symbol;
      logic [dets_pkg::STATE_W-1:0] origin;
      logic [dets_pkg::STATE_W-1:0] target;
   } dfa_request_type;

   typedef struct packed {
      logic [dets_pkg::STATE_W-1:0] state;
      logic                         matched;
      logic                         accepting;
      logic                         table_full;
   } state_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dets_req_if req_bus();
   dets_rsp_if rsp_bus();
   dets_csr_if csr_bus();

   dfa_edge_table_step u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #5 clock = ~clock;

   // Shadow copy of the automaton
   dets_pkg::edge_entry_type     mirror_edges [dets_pkg::MAX_EDGES];
   int                           mirror_count = 0;
   logic [dets_pkg::STATE_W-1:0] mirror_state = '0;
   logic [dets_pkg::STATE_W-1:0] mirror_start = '0;
   logic [dets_pkg::MASK_W-1:0]  mirror_mask = '0;

   dfa_request_type  outgoing_requests[$];
   state_report_type predicted_reports[$];
   logic [dets_pkg::SYM_W-1:0] symbol_pool [4];

   int   idle_pct = 8;
   logic rsp_hold = 1'b0;
   int   mismatches = 0;
   int   requests_taken = 0;
   int   reports_checked = 0;
   int   cycle_count = 0;
   int   register_writes = 0;
   int   phases_run = 0;
   int   appends_seen = 0;
   int   appends_dropped = 0;
   int   steps_seen = 0;
   int   steps_hit = 0;
   int   restarts_seen = 0;
   int   report_only_seen = 0;

   function automatic state_report_type step_automaton(input dfa_request_type r);
      state_report_type rep;
      int i;
      rep.matched = 1'b0;
      rep.table_full = 1'b0;
      case (r.func)
         dets_pkg::FUNC_APPEND: begin
            if (mirror_count >= dets_pkg::MAX_EDGES) begin
               rep.table_full = 1'b1;
            end else begin
               mirror_edges[mirror_count] = '{origin: r.origin, symbol: r.symbol,
                                              target: r.target};
               mirror_count++;
            end
         end
         dets_pkg::FUNC_STEP: begin
            // first edge in load order wins
            for (i = 0; i < mirror_count && !rep.matched; i++) begin
               if (mirror_edges[i].origin == mirror_state &&
                   mirror_edges[i].symbol == r.symbol) begin
                  mirror_state = mirror_edges[i].target;
                  rep.matched = 1'b1;
               end
            end
         end
         dets_pkg::FUNC_RESTART: begin
            mirror_state = mirror_start;
         end
         default: begin
         end
      endcase
      rep.state = mirror_state;
      rep.accepting = (mirror_state < dets_pkg::NUM_STATES && mirror_state < dets_pkg::MASK_W) ?
                      mirror_mask[mirror_state] : 1'b0;
      return rep;
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatches++;
      $display("mismatch on %s after %0d results: got %h, expected %h (at %0t)",
               field, reports_checked, got, want, $time);
   endtask

   // Driver: hold the offered transaction until ready, then advance
   always @(posedge clock) begin
      dfa_request_type  taken;
      dfa_request_type  next_req;
      state_report_type rep;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken = {req_bus.func, req_bus.symbol, req_bus.edge_origin, req_bus.edge_target};
            rep = step_automaton(taken);
            predicted_reports.insert(predicted_reports.size(), rep);
            requests_taken++;
            case (taken.func)
               dets_pkg::FUNC_APPEND: begin
                  appends_seen++;
                  if (rep.table_full) appends_dropped++;
               end
               dets_pkg::FUNC_STEP: begin
                  steps_seen++;
                  if (rep.matched) steps_hit++;
               end
               dets_pkg::FUNC_RESTART: restarts_seen++;
               default: report_only_seen++;
            endcase
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (outgoing_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               next_req = outgoing_requests.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.func <= next_req.func;
               req_bus.symbol <= next_req.symbol;
               req_bus.edge_origin <= next_req.origin;
               req_bus.edge_target <= next_req.target;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result against the oldest prediction
   always @(posedge clock) begin
      state_report_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_reports.size() == 0) begin
               report_mismatch("unexpected result", 16'(rsp_bus.current_state), 16'h0);
            end else begin
               want = predicted_reports.pop_front();
               if (rsp_bus.current_state !== want.state)
                  report_mismatch("current_state", 16'(rsp_bus.current_state),
                                  16'(want.state));
               if (rsp_bus.matched !== want.matched)
                  report_mismatch("matched", 16'(rsp_bus.matched), 16'(want.matched));
               if (rsp_bus.accepting !== want.accepting)
                  report_mismatch("accepting", 16'(rsp_bus.accepting), 16'(want.accepting));
               if (rsp_bus.table_full !== want.table_full)
                  report_mismatch("table_full", 16'(rsp_bus.table_full),
                                  16'(want.table_full));
            end
            reports_checked++;
         end
         rsp_bus.ready <= !rsp_hold && ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // Long receiver stall while the sender keeps offering
   initial begin
      wait (requests_taken >= HOLD_AFTER);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  predicted_reports.size());
         $display("dfa_edge_table_step verification failed");
         $finish;
      end
   end

   task automatic write_register(input logic [dets_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [dets_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == dets_pkg::CSR_START_STATE)
         mirror_start = value[dets_pkg::STATE_W-1:0];
      else
         mirror_mask = value[dets_pkg::MASK_W-1:0];
      register_writes++;
   endtask

   task automatic configure(input logic [dets_pkg::STATE_W-1:0] start,
                            input logic [dets_pkg::MASK_W-1:0] mask);
      write_register(dets_pkg::CSR_START_STATE, dets_pkg::CSR_DATA_W'(start));
      write_register(dets_pkg::CSR_ACCEPT_MASK, dets_pkg::CSR_DATA_W'(mask));
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      do @(negedge clock);
      while (outgoing_requests.size() != 0 || req_bus.valid || predicted_reports.size() != 0);
   endtask

   task automatic queue_req(input logic [dets_pkg::FUNC_W-1:0] func,
                            input logic [dets_pkg::SYM_W-1:0] sym,
                            input logic [dets_pkg::STATE_W-1:0] org,
                            input logic [dets_pkg::STATE_W-1:0] tgt);
      dfa_request_type r;
      r = '{func: func, symbol: sym, origin: org, target: tgt};
      outgoing_requests.insert(outgoing_requests.size(), r);
   endtask

   task automatic queue_random(input int count, input int append_pct, input int step_pct,
                               input int restart_pct);
      dfa_request_type r;
      int roll;
      int k;
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         // mostly pool symbols so steps find edges; the rest is noise
         if ($urandom_range(0, 99) < 85)
            r.symbol = symbol_pool[$urandom_range(0, 3)];
         else
            r.symbol = dets_pkg::SYM_W'($urandom_range(0, 255));
         r.origin = dets_pkg::STATE_W'($urandom_range(0, 15));
         r.target = dets_pkg::STATE_W'($urandom_range(0, 15));
         if (roll < append_pct)
            r.func = dets_pkg::FUNC_APPEND;
         else if (roll < append_pct + step_pct)
            r.func = dets_pkg::FUNC_STEP;
         else if (roll < append_pct + step_pct + restart_pct)
            r.func = dets_pkg::FUNC_RESTART;
         else
            r.func = FUNC_REPORT;
         outgoing_requests.insert(outgoing_requests.size(), r);
      end
      phases_run++;
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.func = dets_pkg::FUNC_APPEND;
      req_bus.symbol = '0;
      req_bus.edge_origin = '0;
      req_bus.edge_target = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = dets_pkg::CSR_START_STATE;
      csr_bus.data = '0;
      symbol_pool[0] = 8'h00;
      symbol_pool[1] = 8'hff;
      symbol_pool[2] = dets_pkg::SYM_W'($urandom_range(1, 254));
      symbol_pool[3] = dets_pkg::SYM_W'($urandom_range(1, 254));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: empty table, state zero, start zero, mask clear
      queue_req(dets_pkg::FUNC_STEP, 8'hff, 4'h0, 4'h0);
      queue_req(FUNC_REPORT, 8'ha5, 4'hf, 4'hf);
      queue_req(dets_pkg::FUNC_RESTART, 8'h00, 4'h0, 4'h0);
      wait_for_drain();

      configure(4'hf, 16'h8000);
      queue_req(dets_pkg::FUNC_RESTART, 8'h3c, 4'h5, 4'ha);
      queue_req(dets_pkg::FUNC_APPEND, 8'h00, 4'hf, 4'h0);
      queue_req(dets_pkg::FUNC_APPEND, 8'h00, 4'hf, 4'h7);   // shadowed by the earlier edge
      queue_req(dets_pkg::FUNC_APPEND, 8'hff, 4'h0, 4'hf);
      queue_req(dets_pkg::FUNC_APPEND, 8'hff, 4'hf, 4'hf);
      queue_req(dets_pkg::FUNC_STEP, 8'h00, 4'h0, 4'h0);
      queue_req(dets_pkg::FUNC_STEP, 8'h00, 4'hf, 4'hf);     // no edge out of state 0 on symbol 00 yet
      queue_req(dets_pkg::FUNC_STEP, 8'hff, 4'h0, 4'h0);
      queue_req(dets_pkg::FUNC_STEP, 8'hff, 4'h0, 4'h0);     // self loop
      queue_req(dets_pkg::FUNC_STEP, 8'h5a, 4'h0, 4'h0);
      queue_req(FUNC_REPORT, 8'h00, 4'h0, 4'h0);
      queue_req(dets_pkg::FUNC_APPEND, 8'h00, 4'h0, 4'h0);
      queue_req(dets_pkg::FUNC_RESTART, 8'h00, 4'h0, 4'h0);
      queue_req(dets_pkg::FUNC_STEP, 8'h00, 4'hf, 4'hf);
      queue_req(dets_pkg::FUNC_STEP, 8'h00, 4'h0, 4'h0);
      queue_req(FUNC_REPORT, 8'hff, 4'h0, 4'hf);
      wait_for_drain();

      // fill the table and run past it, receiver stall lands here
      configure(4'h0, 16'hffff);
      queue_random(300, 30, 50, 12);
      wait_for_drain();

      // steady stretch, no idling on either side
      idle_pct = 0;
      configure(dets_pkg::STATE_W'($urandom_range(1, 14)),
                dets_pkg::MASK_W'($urandom_range(0, 65535)));
      queue_random(280, 8, 74, 10);
      wait_for_drain();

      idle_pct = 8;
      configure(4'hf, 16'h0000);
      queue_random(260, 10, 72, 10);
      wait_for_drain();

      configure(dets_pkg::STATE_W'($urandom_range(0, 15)),
                dets_pkg::MASK_W'($urandom_range(0, 65535)));
      queue_random(240, 15, 65, 12);
      wait_for_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (predicted_reports.size() != 0)
         report_mismatch("results never returned", 16'(predicted_reports.size()), 16'h0);

      $display("ran %0d requests in %0d random phases: %0d appends (%0d dropped), %0d steps",
               requests_taken, phases_run, appends_seen, appends_dropped, steps_seen);
      $display("%0d steps matched, %0d restarts, %0d report-only, %0d register writes",
               steps_hit, restarts_seen, report_only_seen, register_writes);
      if (mismatches == 0) begin
         $display("dfa_edge_table_step verification clean");
      end else begin
         $display("dfa_edge_table_step verification failed");
      end
      $finish;
   end

endmodule
